[hw/rtl/hmc_pkg.sv]
// Shared types, sizes and constants of the height map classifier.
// Used by every module of the block except hmc_ram; depends on nothing.
package hmc_pkg;

	// Grid edge length; the grid holds GRID*GRID samples and is a power of two.
	localparam int GRID = 64;
	localparam int CELLS = GRID * GRID;
	localparam int AW = $clog2(CELLS);
	localparam int CNT_W = $clog2(CELLS + 1);

	// Q15.8 height and its derived widths
	localparam int H_W = 24;
	localparam int SUM_W = H_W + AW;
	localparam int V_W = H_W + 2;
	localparam int F_W = 16;
	localparam int PROD_W = V_W + F_W;
	localparam int Q14_SHIFT = 14;

	localparam int CFG_W = 7;
	localparam int RC_W = 6;

	// 999.0 in Q15.8
	localparam logic signed [H_W-1:0] MIN_RESET = 24'sd255744;

	// Q2.14 class factors
	localparam logic signed [F_W-1:0] F_WATER = 16'sd3277;
	localparam logic signed [F_W-1:0] F_GROUND = 16'sd11469;
	localparam logic signed [F_W-1:0] F_HILL = 16'sd21299;
	localparam logic signed [F_W-1:0] F_MOUNT = 16'sd13107;

	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	localparam logic REG_MAP_COLUMNS = 1'b0;
	localparam logic REG_MAP_ROWS = 1'b1;

	typedef enum logic [2:0] {
		CLS_SEA,
		CLS_SHALLOW,
		CLS_GRASS,
		CLS_HILLS,
		CLS_MOUNTAIN
	} hmc_class_t;

	// Grid statistics handed from the statistics unit to the classifier
	typedef struct packed {
		logic full;
		logic signed [V_W-1:0] off;
		logic signed [PROD_W-1:0] t_water;
		logic signed [PROD_W-1:0] t_ground;
		logic signed [PROD_W-1:0] t_hill;
		logic signed [PROD_W-1:0] t_mount;
	} hmc_stat_t;

endpackage

[hw/rtl/hmc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.
module hmc_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hw/rtl/hmc_stats.sv]
// Load counter, running min/max/sum and registered class limits.
// Depends on hmc_pkg.
module hmc_stats (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            load_en,
	input  logic signed [hmc_pkg::H_W-1:0]  height,
	output logic [hmc_pkg::AW-1:0]          wr_addr,
	output hmc_pkg::hmc_stat_t              stat
);
	import hmc_pkg::*;

	logic [CNT_W-1:0]        count_q;
	logic signed [H_W-1:0]   min_q;
	logic signed [H_W-1:0]   max_q;
	logic signed [SUM_W-1:0] sum_q;
	logic                    full;

	logic signed [V_W-1:0]    off;
	logic signed [V_W-1:0]    mx;
	logic signed [V_W-1:0]    av;
	logic signed [SUM_W-1:0]  avg_floor;
	logic signed [V_W-1:0]    off_q;
	logic signed [PROD_W-1:0] t_water_q;
	logic signed [PROD_W-1:0] t_ground_q;
	logic signed [PROD_W-1:0] t_hill_q;
	logic signed [PROD_W-1:0] t_mount_q;

	assign full = (count_q == CNT_W'(CELLS));
	assign wr_addr = count_q[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			min_q <= MIN_RESET;
			max_q <= '0;
			sum_q <= '0;
		end else if (load_en && !full) begin
			count_q <= count_q + CNT_W'(1);
			if (height < min_q) begin
				min_q <= height;
			end
			if (height > max_q) begin
				max_q <= height;
			end
			sum_q <= sum_q + SUM_W'(height);
		end
	end

	// Shift the grid up by the magnitude of a negative minimum
	always_comb begin
		off = (min_q < 0) ? -V_W'(min_q) : '0;
		mx = V_W'(max_q) + off;
		avg_floor = sum_q >>> AW;
		av = V_W'(signed'(avg_floor[H_W-1:0])) + off;
	end

	// Limits are a register behind the statistics; they settle before
	// the first query can reach the compare stage.
	always_ff @(posedge clk) begin
		off_q <= off;
		t_water_q <= PROD_W'(F_WATER) * PROD_W'(mx);
		t_ground_q <= PROD_W'(F_GROUND) * PROD_W'(av);
		t_hill_q <= PROD_W'(F_HILL) * PROD_W'(av);
		t_mount_q <= PROD_W'(F_MOUNT) * PROD_W'(mx);
	end

	assign stat.full = full;
	assign stat.off = off_q;
	assign stat.t_water = t_water_q;
	assign stat.t_ground = t_ground_q;
	assign stat.t_hill = t_hill_q;
	assign stat.t_mount = t_mount_q;

endmodule

[hw/rtl/hmc_classify.sv]
// Compare of one shifted cell height against the four class limits.
// Depends on hmc_pkg.
module hmc_classify (
	input  logic signed [hmc_pkg::H_W-1:0] value,
	input  hmc_pkg::hmc_stat_t             stat,
	output hmc_pkg::hmc_class_t            terrain
);
	import hmc_pkg::*;

	logic signed [V_W-1:0]    shifted;
	logic signed [PROD_W-1:0] scaled;

	always_comb begin
		shifted = V_W'(value) + stat.off;
		scaled = PROD_W'(shifted) <<< Q14_SHIFT;
		// a value equal to a limit falls into the higher class
		priority if (scaled < stat.t_water) begin
			terrain = CLS_SEA;
		end else if (scaled < stat.t_ground) begin
			terrain = CLS_SHALLOW;
		end else if (scaled < stat.t_hill) begin
			terrain = CLS_GRASS;
		end else if (scaled < stat.t_mount) begin
			terrain = CLS_HILLS;
		end else begin
			terrain = CLS_MOUNTAIN;
		end
	end

endmodule

[hw/rtl/height_map_classifier.sv]
// Height map classifier top level: request/response pipeline around the
// height store, the statistics unit and the class compare.
// Depends on hmc_pkg, hmc_ram, hmc_stats and hmc_classify.
//
// The block takes one request per cycle. A load (action 0) writes the next
// Q15.8 sample of the GRID x GRID grid in raster order and updates the running
// min, max and sum; it gives no response, and loads past a full grid are
// dropped. A query (action 1) gives exactly one response to its transfer:
// terrain_class plus the not_ready and out_of_map flags, with terrain_class
// forced to sea whenever a flag is set. The response passes the registered
// read port of the height store and then the response register. Requests,
// responses and throughput are one per cycle; the request side stalls only
// while a response waits on a stalled consumer. The class limits are
// registered from the statistics after the last load, which always lands
// before the first query compare. The user must write map_columns and
// map_rows through the cfg port while the block is idle; this is not enforced.
module height_map_classifier (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration
	input  logic                            cfg_we,
	input  logic                            cfg_index,
	input  logic [hmc_pkg::CFG_W-1:0]       cfg_data,
	// request channel
	input  logic                            req_valid,
	output logic                            req_stall,
	input  logic                            action,
	input  logic signed [hmc_pkg::H_W-1:0]  height,
	input  logic [hmc_pkg::RC_W-1:0]        col,
	input  logic [hmc_pkg::RC_W-1:0]        row,
	// response channel
	output logic                            rsp_valid,
	input  logic                            rsp_stall,
	output logic [2:0]                      terrain_class,
	output logic                            not_ready,
	output logic                            out_of_map
);
	import hmc_pkg::*;

	logic [CFG_W-1:0] map_columns_q;
	logic [CFG_W-1:0] map_rows_q;

	logic       adv;
	logic       req_xfer;
	logic       load_en;
	logic       query;
	logic       oom;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;
	hmc_stat_t  stat;
	logic [H_W-1:0] rd_data;
	hmc_class_t cls;

	logic       valid_s1;
	logic       nr_s1;
	logic       oom_s1;
	logic       valid_s2;
	hmc_class_t class_s2;
	logic       nr_s2;
	logic       oom_s2;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_columns_q <= CFG_W'(64);
			map_rows_q <= CFG_W'(64);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MAP_COLUMNS: map_columns_q <= cfg_data;
				REG_MAP_ROWS:    map_rows_q <= cfg_data;
				default:         map_rows_q <= map_rows_q;
			endcase
		end
	end

	// The whole pipeline advances together; hold it only while a finished
	// response is stalled.
	assign adv = !(valid_s2 && rsp_stall);
	assign req_stall = !adv;
	assign req_xfer = req_valid && adv;
	assign load_en = req_xfer && (action == ACT_LOAD);
	assign query = req_xfer && (action == ACT_QUERY);

	// Cell outside the target map or the grid itself
	assign oom = (CFG_W'(col) >= map_columns_q) || (CFG_W'(row) >= map_rows_q) ||
		(32'(col) >= GRID) || (32'(row) >= GRID);
	assign rd_addr = AW'(32'(row) * GRID + 32'(col));

	hmc_stats u_stats (
		.clk     (clk),
		.arst_n  (arst_n),
		.load_en (load_en),
		.height  (height),
		.wr_addr (wr_addr),
		.stat    (stat)
	);

	// Height store: written on load, read whenever the pipeline advances; read
	// data is held while the pipeline stalls.
	hmc_ram #(
		.WIDTH (H_W),
		.DEPTH (CELLS)
	) u_store (
		.clk   (clk),
		.we    (load_en && !stat.full),
		.waddr (wr_addr),
		.wdata (height),
		.re    (adv),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	hmc_classify u_classify (
		.value   (signed'(rd_data)),
		.stat    (stat),
		.terrain (cls)
	);

	// Stage 1: flags travel alongside the store read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= query;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			nr_s1 <= !stat.full;
			oom_s1 <= oom;
		end
	end

	// Stage 2: response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			class_s2 <= (nr_s1 || oom_s1) ? CLS_SEA : cls;
			nr_s2 <= nr_s1;
			oom_s2 <= oom_s1;
		end
	end

	assign rsp_valid = valid_s2;
	assign terrain_class = class_s2;
	assign not_ready = nr_s2;
	assign out_of_map = oom_s2;

endmodule
